// ===== hdl/wrsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrsd_pkg: shared types and constants of the windowed RMS silence detector
// Field widths, register indexes, reset values and the beat structs.
// ----------------------------------------------------------------------------
package wrsd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int POS_BITS    = 32;
    localparam int WIN_BITS    = 16;

    localparam int THR_BITS    = 31;
    localparam int WLEN_BITS   = 16;
    localparam int MIN_BITS    = 32;
    localparam int OUT_BITS    = 32;

    // largest square is (2^(SAMPLE_BITS-1))^2
    localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_BITS = SQ_BITS + WIN_BITS;
    localparam int PROD_BITS   = THR_BITS + WIN_BITS;
    localparam int CMP_BITS    = (ENERGY_BITS > PROD_BITS) ? ENERGY_BITS : PROD_BITS;
    localparam int LEN_BITS    = (POS_BITS > MIN_BITS) ? POS_BITS : MIN_BITS;
    localparam int WCMP_BITS   = (WIN_BITS > WLEN_BITS) ? WIN_BITS : WLEN_BITS;

    // output queue
    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_BITS = OUTQ_PTR_BITS + 1;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD_SQ    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RUN_SAMPLES = 2'd2;

    localparam logic [THR_BITS-1:0]  RST_THRESHOLD_SQ    = 31'd1074;
    localparam logic [WLEN_BITS-1:0] RST_WINDOW_LEN      = 16'd2400;
    localparam logic [MIN_BITS-1:0]  RST_MIN_RUN_SAMPLES = 32'd24000;

    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in;

    typedef struct packed {
        logic                kind;
        logic [OUT_BITS-1:0] run_start;
        logic [OUT_BITS-1:0] run_end;
        logic [OUT_BITS-1:0] leading_len;
        logic [OUT_BITS-1:0] trailing_len;
        logic                final_item;
    } t_out;

endpackage
`default_nettype wire

// ===== hdl/windowed_rms_silence_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_rms_silence_detector_unit: silent-run finder over windowed energy
// Sums squared samples per window, marks windows with mean square at or below
// threshold_sq as silent, merges silent windows into runs and reports runs of
// at least min_run_samples, plus a summary beat on the last sample.
// ----------------------------------------------------------------------------
// Takes one sample per clock while input ready is high. A sample moves through
// six register stages (input, square, accumulate, threshold product, compare,
// run tracking) and its result beats land in a four-entry output queue. A
// sample causes zero, one or two beats (a run report, then the summary on the
// last sample). Input ready drops only while more than two beats sit in the
// queue, i.e. while the consumer holds off. Configuration writes take effect at
// once and belong to idle periods.
module windowed_rms_silence_detector_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire [wrsd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire [wrsd_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire wrsd_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output wrsd_pkg::t_out                       o_out_data
);

    // configuration
    logic [wrsd_pkg::THR_BITS-1:0]  r_thr;
    logic [wrsd_pkg::WLEN_BITS-1:0] r_wlen;
    logic [wrsd_pkg::MIN_BITS-1:0]  r_min_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= wrsd_pkg::RST_THRESHOLD_SQ;
            r_wlen    <= wrsd_pkg::RST_WINDOW_LEN;
            r_min_run <= wrsd_pkg::RST_MIN_RUN_SAMPLES;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                wrsd_pkg::CFG_THRESHOLD_SQ:    r_thr     <= i_cfg_wdata[wrsd_pkg::THR_BITS-1:0];
                wrsd_pkg::CFG_WINDOW_LEN:      r_wlen    <= i_cfg_wdata[wrsd_pkg::WLEN_BITS-1:0];
                wrsd_pkg::CFG_MIN_RUN_SAMPLES: r_min_run <= i_cfg_wdata[wrsd_pkg::MIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: whole pipe moves when the queue has room for two beats
    logic [wrsd_pkg::OUTQ_CNT_BITS-1:0] r_q_cnt;
    logic                               en;
    assign en         = (r_q_cnt <= wrsd_pkg::OUTQ_CNT_BITS'(wrsd_pkg::OUTQ_DEPTH - 2));
    assign o_in_ready = en;

    // stage 0: input register
    logic          r_v0;
    wrsd_pkg::t_in r_s0_in;

    // stage 1: square
    logic                                r_v1;
    logic [wrsd_pkg::SQ_BITS-1:0]        r_s1_sq;
    logic                                r_s1_last;
    logic signed [2*wrsd_pkg::SAMPLE_BITS-1:0] sq_full;

    assign sq_full = r_s0_in.sample * r_s0_in.sample;

    // stage 2: accumulate
    logic [wrsd_pkg::ENERGY_BITS-1:0] r_energy;
    logic [wrsd_pkg::WIN_BITS-1:0]    r_count;
    logic [wrsd_pkg::POS_BITS-1:0]    r_pos;

    logic [wrsd_pkg::ENERGY_BITS:0]   energy_sum;
    logic [wrsd_pkg::ENERGY_BITS-1:0] energy_acc;
    logic [wrsd_pkg::WIN_BITS-1:0]    count_inc;
    logic [wrsd_pkg::POS_BITS-1:0]    pos_inc;
    logic [wrsd_pkg::WLEN_BITS-1:0]   len_eff;
    logic                             flush;

    assign energy_sum = {1'b0, r_energy} + (wrsd_pkg::ENERGY_BITS + 1)'(r_s1_sq);
    assign energy_acc = energy_sum[wrsd_pkg::ENERGY_BITS] ? '1
                                                          : energy_sum[wrsd_pkg::ENERGY_BITS-1:0];
    assign count_inc  = (r_count == '1) ? r_count : r_count + 1'b1;
    assign pos_inc    = (r_pos == '1) ? r_pos : r_pos + 1'b1;
    assign len_eff    = (r_wlen == '0) ? wrsd_pkg::WLEN_BITS'(1) : r_wlen;
    // a saturated count also closes the window: lengths past it clamp to it
    assign flush      = (wrsd_pkg::WCMP_BITS'(count_inc) >= wrsd_pkg::WCMP_BITS'(len_eff))
                      || (count_inc == '1) || r_s1_last;

    logic                             r_v2;
    logic [wrsd_pkg::ENERGY_BITS-1:0] r_s2_energy;
    logic [wrsd_pkg::WIN_BITS-1:0]    r_s2_count;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s2_pos;
    logic                             r_s2_flush;
    logic                             r_s2_last;

    // stage 3: threshold product and window start
    logic [wrsd_pkg::PROD_BITS-1:0]   prod;
    logic [wrsd_pkg::POS_BITS-1:0]    wstart;

    assign prod   = wrsd_pkg::PROD_BITS'(r_thr) * wrsd_pkg::PROD_BITS'(r_s2_count);
    assign wstart = (r_s2_pos >= wrsd_pkg::POS_BITS'(r_s2_count))
                  ? r_s2_pos - wrsd_pkg::POS_BITS'(r_s2_count) : '0;

    logic                             r_v3;
    logic [wrsd_pkg::ENERGY_BITS-1:0] r_s3_energy;
    logic [wrsd_pkg::PROD_BITS-1:0]   r_s3_prod;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s3_pos;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s3_wstart;
    logic                             r_s3_flush;
    logic                             r_s3_last;

    // stage 4: silence compare
    logic                             r_v4;
    logic                             r_s4_silent;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s4_pos;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s4_wstart;
    logic                             r_s4_flush;
    logic                             r_s4_last;

    // stage 5: run tracking
    logic                             r_run_open;
    logic [wrsd_pkg::POS_BITS-1:0]    r_open_start;
    logic                             r_first_done;
    logic [wrsd_pkg::POS_BITS-1:0]    r_leading;
    logic                             r_any_rep;
    logic [wrsd_pkg::POS_BITS-1:0]    r_last_start;
    logic [wrsd_pkg::POS_BITS-1:0]    r_last_end;

    logic                             close_mid;
    logic                             open_now;
    logic                             open_after;
    logic                             do_close;
    logic [wrsd_pkg::POS_BITS-1:0]    c_start;
    logic [wrsd_pkg::POS_BITS-1:0]    c_end;
    logic [wrsd_pkg::POS_BITS-1:0]    c_len;
    logic                             report;
    logic                             n_first_done;
    logic [wrsd_pkg::POS_BITS-1:0]    n_leading;
    logic                             n_any_rep;
    logic [wrsd_pkg::POS_BITS-1:0]    n_last_start;
    logic [wrsd_pkg::POS_BITS-1:0]    n_last_end;

    assign close_mid  = r_s4_flush && !r_s4_silent && r_run_open;
    assign open_now   = r_s4_flush && r_s4_silent && !r_run_open;
    assign open_after = r_run_open ? !close_mid : open_now;
    assign do_close   = close_mid || (r_s4_last && open_after);
    assign c_start    = r_run_open ? r_open_start : r_s4_wstart;
    assign c_end      = close_mid ? r_s4_wstart : r_s4_pos;
    assign c_len      = (c_end >= c_start) ? c_end - c_start : '0;
    assign report     = do_close
                      && (wrsd_pkg::LEN_BITS'(c_len) >= wrsd_pkg::LEN_BITS'(r_min_run));

    always_comb begin
        n_first_done = r_first_done;
        n_leading    = r_leading;
        n_any_rep    = r_any_rep;
        n_last_start = r_last_start;
        n_last_end   = r_last_end;
        if (report) begin
            n_any_rep    = 1'b1;
            n_last_start = c_start;
            n_last_end   = c_end;
            if (!r_first_done) begin
                n_first_done = 1'b1;
                n_leading    = (c_start == '0) ? c_end : '0;
            end
        end
    end

    logic                             r_v5;
    logic                             r_s5_rep;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s5_start;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s5_end;
    logic                             r_s5_last;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s5_pos;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s5_leading;
    logic                             r_s5_any;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s5_lrs;
    logic [wrsd_pkg::POS_BITS-1:0]    r_s5_lre;

    // stage 6: beat assembly into the output queue
    logic [wrsd_pkg::POS_BITS-1:0]      trail;
    wrsd_pkg::t_out                     rep_beat;
    wrsd_pkg::t_out                     sum_beat;
    logic                               wr_rep;
    logic                               wr_sum;
    logic [wrsd_pkg::OUTQ_CNT_BITS-1:0] wr_num;
    logic                               pop;

    assign trail = (r_s5_any && r_s5_lre >= r_s5_pos) ? r_s5_pos - r_s5_lrs : '0;

    always_comb begin
        rep_beat              = '0;
        rep_beat.kind         = wrsd_pkg::KIND_RUN;
        rep_beat.run_start    = wrsd_pkg::OUT_BITS'(r_s5_start);
        rep_beat.run_end      = wrsd_pkg::OUT_BITS'(r_s5_end);
        sum_beat              = '0;
        sum_beat.kind         = wrsd_pkg::KIND_SUMMARY;
        sum_beat.run_end      = wrsd_pkg::OUT_BITS'(r_s5_pos);
        sum_beat.leading_len  = wrsd_pkg::OUT_BITS'(r_s5_leading);
        sum_beat.trailing_len = wrsd_pkg::OUT_BITS'(trail);
        sum_beat.final_item   = 1'b1;
    end

    assign wr_rep = en && r_v5 && r_s5_rep;
    assign wr_sum = en && r_v5 && r_s5_last;
    assign wr_num = wrsd_pkg::OUTQ_CNT_BITS'(wr_rep) + wrsd_pkg::OUTQ_CNT_BITS'(wr_sum);

    wrsd_pkg::t_out                     r_q_mem [wrsd_pkg::OUTQ_DEPTH];
    logic [wrsd_pkg::OUTQ_PTR_BITS-1:0] r_wr_ptr;
    logic [wrsd_pkg::OUTQ_PTR_BITS-1:0] r_rd_ptr;

    assign o_out_valid = (r_q_cnt != '0);
    assign o_out_data  = r_q_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_v5         <= 1'b0;
            r_energy     <= '0;
            r_count      <= '0;
            r_pos        <= '0;
            r_run_open   <= 1'b0;
            r_open_start <= '0;
            r_first_done <= 1'b0;
            r_leading    <= '0;
            r_any_rep    <= 1'b0;
            r_last_start <= '0;
            r_last_end   <= '0;
            r_q_cnt      <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
        end else begin
            if (en) begin
                r_v0 <= i_in_valid;
                r_v1 <= r_v0;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
            end
            if (en && r_v1) begin
                r_energy <= flush ? '0 : energy_acc;
                r_count  <= flush ? '0 : count_inc;
                r_pos    <= r_s1_last ? '0 : pos_inc;
            end
            if (en && r_v4) begin
                if (r_s4_last) begin
                    // range closed: next sample starts a new range
                    r_run_open   <= 1'b0;
                    r_open_start <= '0;
                    r_first_done <= 1'b0;
                    r_leading    <= '0;
                    r_any_rep    <= 1'b0;
                    r_last_start <= '0;
                    r_last_end   <= '0;
                end else begin
                    r_run_open   <= open_after;
                    r_open_start <= open_now ? r_s4_wstart : r_open_start;
                    r_first_done <= n_first_done;
                    r_leading    <= n_leading;
                    r_any_rep    <= n_any_rep;
                    r_last_start <= n_last_start;
                    r_last_end   <= n_last_end;
                end
            end
            r_q_cnt  <= r_q_cnt + wr_num - wrsd_pkg::OUTQ_CNT_BITS'(pop);
            r_wr_ptr <= r_wr_ptr + wrsd_pkg::OUTQ_PTR_BITS'(wr_num);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_in      <= i_in_data;

            r_s1_sq      <= sq_full[wrsd_pkg::SQ_BITS-1:0];
            r_s1_last    <= r_s0_in.last;

            r_s2_energy  <= energy_acc;
            r_s2_count   <= count_inc;
            r_s2_pos     <= pos_inc;
            r_s2_flush   <= flush;
            r_s2_last    <= r_s1_last;

            r_s3_energy  <= r_s2_energy;
            r_s3_prod    <= prod;
            r_s3_pos     <= r_s2_pos;
            r_s3_wstart  <= wstart;
            r_s3_flush   <= r_s2_flush;
            r_s3_last    <= r_s2_last;

            r_s4_silent  <= (wrsd_pkg::CMP_BITS'(r_s3_energy) <= wrsd_pkg::CMP_BITS'(r_s3_prod));
            r_s4_pos     <= r_s3_pos;
            r_s4_wstart  <= r_s3_wstart;
            r_s4_flush   <= r_s3_flush;
            r_s4_last    <= r_s3_last;

            r_s5_rep     <= report;
            r_s5_start   <= c_start;
            r_s5_end     <= c_end;
            r_s5_last    <= r_s4_last;
            r_s5_pos     <= r_s4_pos;
            r_s5_leading <= n_leading;
            r_s5_any     <= n_any_rep;
            r_s5_lrs     <= n_last_start;
            r_s5_lre     <= n_last_end;
        end
        if (wr_rep) begin
            r_q_mem[r_wr_ptr] <= rep_beat;
        end
        if (wr_sum) begin
            r_q_mem[wr_rep ? r_wr_ptr + 1'b1 : r_wr_ptr] <= sum_beat;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/wrsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrsd_checker: port-level checks for the silence detector
// Watches input and output beats for stall behavior and field consistency.
// ----------------------------------------------------------------------------
module wrsd_checker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  wire                                  o_in_ready,
    input  wire wrsd_pkg::t_in                   i_in_data,
    input  wire                                  o_out_valid,
    input  wire                                  i_out_ready,
    input  wire wrsd_pkg::t_out                  o_out_data
);

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while waiting");

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // only the summary closes the range
    a_final_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.final_item == o_out_data.kind))
        else $error("final_item does not match kind");

    // run beats: ordered indices, no summary lengths
    a_run_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == wrsd_pkg::KIND_RUN) |->
            (o_out_data.run_start <= o_out_data.run_end)
            && (o_out_data.leading_len == '0) && (o_out_data.trailing_len == '0))
        else $error("malformed run beat");

    // summary: silence lengths fit inside the range
    a_sum_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == wrsd_pkg::KIND_SUMMARY) |->
            (o_out_data.run_start == '0)
            && (o_out_data.leading_len <= o_out_data.run_end)
            && (o_out_data.trailing_len <= o_out_data.run_end))
        else $error("malformed summary beat");

endmodule

bind windowed_rms_silence_detector_unit wrsd_checker u_wrsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
